FILE: sv/rkmp_pkg.sv
package rkmp_pkg;

  localparam int unsigned MaxDigits = 18;
  localparam int unsigned MaxLength = 32;

  localparam int unsigned CharW  = 8;
  localparam int unsigned MantW  = 60;
  localparam int unsigned ExpW   = 7;
  localparam int unsigned SigW   = 5;
  localparam int unsigned FracW  = 6;
  localparam int unsigned DotW   = 2;
  localparam int unsigned CntW   = 6;
  localparam int unsigned LexpW  = 5;
  localparam int unsigned ExpCalcW = 8;

  localparam logic [CharW-1:0] ChDot    = 8'h2E;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChUpA    = 8'h41;
  localparam logic [CharW-1:0] ChUpZ    = 8'h5A;
  localparam logic [CharW-1:0] ChLowA   = 8'h61;
  localparam logic [CharW-1:0] ChLowZ   = 8'h7A;
  localparam logic [CharW-1:0] ChUpM    = 8'h4D;
  localparam logic [CharW-1:0] ChLowP   = 8'h70;
  localparam logic [CharW-1:0] ChLowN   = 8'h6E;
  localparam logic [CharW-1:0] ChLowU   = 8'h75;
  localparam logic [CharW-1:0] ChLowM   = 8'h6D;
  localparam logic [CharW-1:0] ChLowK   = 8'h6B;
  localparam logic [CharW-1:0] ChLowG   = 8'h67;
  localparam logic [CharW-1:0] ChLowR   = 8'h72;
  localparam logic [CharW-1:0] ChLowE   = 8'h65;
  localparam logic [CharW-1:0] CaseBit  = 8'h20;

  typedef enum logic [3:0] {
    LET_NONE  = 4'd0,
    LET_P     = 4'd1,
    LET_N     = 4'd2,
    LET_U     = 4'd3,
    LET_M_LOW = 4'd4,
    LET_M_UP  = 4'd5,
    LET_K     = 4'd6,
    LET_G     = 4'd7,
    LET_R     = 4'd8
  } letter_e;

  typedef struct packed {
    logic [MantW-1:0] acc;
    logic [SigW-1:0]  sig_cnt;
    logic [FracW-1:0] frac_cnt;
    logic [DotW-1:0]  dot_cnt;
    logic             digit_seen;
    letter_e          letter;
    logic             tail;
    logic             err;
    logic [CntW-1:0]  char_cnt;
  } rkmp_state_t;

  function automatic letter_e letter_of(input logic [CharW-1:0] c);
    logic [CharW-1:0] lc;
    letter_e          code;
    lc = c | CaseBit;
    case (lc)
      ChLowP:         code = LET_P;
      ChLowN:         code = LET_N;
      ChLowU:         code = LET_U;
      ChLowM:         code = LET_M_LOW;
      ChLowK:         code = LET_K;
      ChLowG:         code = LET_G;
      ChLowR, ChLowE: code = LET_R;
      default:        code = LET_NONE;
    endcase
    if (c == ChUpM) code = LET_M_UP;
    return code;
  endfunction

  function automatic logic signed [LexpW-1:0] letter_exp(input letter_e code,
                                                         input logic res_like);
    logic signed [LexpW-1:0] e;
    case (code)
      LET_P:     e = -5'sd12;
      LET_N:     e = -5'sd9;
      LET_U:     e = -5'sd6;
      LET_M_LOW: e = res_like ? 5'sd6 : -5'sd3;
      LET_M_UP:  e = 5'sd6;
      LET_K:     e = 5'sd3;
      LET_G:     e = 5'sd9;
      default:   e = 5'sd0;
    endcase
    return e;
  endfunction

endpackage

FILE: sv/rkmp_if.sv
interface rkmp_char_if;
  import rkmp_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last_char;
  logic             resistance_like;

  modport source(output valid, char_code, last_char, resistance_like, input ready);
  modport sink(input valid, char_code, last_char, resistance_like, output ready);
endinterface

interface rkmp_value_if;
  import rkmp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    value_valid;
  logic [MantW-1:0]        mantissa;
  logic signed [ExpW-1:0]  exponent;

  modport source(output valid, value_valid, mantissa, exponent, input ready);
  modport sink(input valid, value_valid, mantissa, exponent, output ready);
endinterface

FILE: sv/rkmp_step.sv
module rkmp_step (
  input  rkmp_pkg::rkmp_state_t        state_i,
  input  logic [rkmp_pkg::CharW-1:0]   char_code_i,
  output rkmp_pkg::rkmp_state_t        state_o
);
  import rkmp_pkg::*;

  logic              is_digit;
  logic              is_dot;
  logic              is_letter;
  logic [3:0]        digit;
  logic [MantW+3:0]  acc_x10;
  letter_e           code;

  assign is_digit  = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  assign is_dot    = (char_code_i == ChDot);
  assign is_letter = ((char_code_i >= ChUpA) && (char_code_i <= ChUpZ)) ||
                     ((char_code_i >= ChLowA) && (char_code_i <= ChLowZ));
  assign digit     = char_code_i[3:0];
  assign acc_x10   = ({4'b0, state_i.acc} << 3) + ({4'b0, state_i.acc} << 1) +
                     {{MantW{1'b0}}, digit};
  assign code      = letter_of(char_code_i);

  always_comb begin
    state_o = state_i;
    if (state_i.char_cnt != {CntW{1'b1}}) state_o.char_cnt = state_i.char_cnt + 1'b1;
    if (state_i.letter != LET_NONE) state_o.tail = 1'b1;

    if (is_digit) begin
      state_o.digit_seen = 1'b1;
      if ((state_i.dot_cnt != '0 || state_i.letter != LET_NONE) &&
          state_i.frac_cnt != {FracW{1'b1}}) begin
        state_o.frac_cnt = state_i.frac_cnt + 1'b1;
      end
      if (state_i.acc != '0 || digit != 4'd0) begin
        if (state_i.sig_cnt <= SigW'(MaxDigits)) begin
          state_o.sig_cnt = state_i.sig_cnt + 1'b1;
          // mantissa overflow past 60 bits
          if (acc_x10[MantW+3:MantW] != 4'd0) begin
            state_o.err = 1'b1;
          end else begin
            state_o.acc = acc_x10[MantW-1:0];
          end
        end
      end
    end else if (is_dot) begin
      if (state_i.dot_cnt != {DotW{1'b1}}) state_o.dot_cnt = state_i.dot_cnt + 1'b1;
    end else if (is_letter) begin
      if (state_i.letter != LET_NONE || code == LET_NONE) begin
        state_o.err = 1'b1;
      end else begin
        state_o.letter = code;
      end
    end else begin
      state_o.err = 1'b1;
    end
  end

endmodule

FILE: sv/rkm_value_code_parser.sv
// Value token parser: reads a component value such as 4R7, 1u5, 4.7k or 100
// one character per transfer on char_i and reports the parsed value on value_o.
// Each char_i transfer carries one character; last_char marks the end of the
// token, and resistance_like is taken with that last character.
// Only the last character yields a value_o transfer: value_valid, a decimal
// mantissa and a signed power-of-ten exponent (mantissa and exponent are zero
// when the token is rejected). The parser then clears for the next token.
// Throughput: one character per cycle while char_i.ready is high. Latency:
// the result is on value_o in the cycle after the last character's transfer,
// set by the one result register behind the per-character accumulator update.
// Stall: while a result waits and value_o.ready is low, char_i.ready drops;
// it stays high whenever the result register is empty or being drained.
// Reset clears the token state and empties the result register.
module rkm_value_code_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  rkmp_char_if.sink     char_i,
  rkmp_value_if.source  value_o
);
  import rkmp_pkg::*;

  rkmp_state_t             state_q;
  rkmp_state_t             state_n;
  logic                    take;
  logic                    finish;
  logic signed [ExpCalcW-1:0] lexp_ext;
  logic signed [ExpCalcW-1:0] expo;
  logic                    ok;

  logic                    out_vld_q;
  logic                    vv_q;
  logic [MantW-1:0]        mant_q;
  logic signed [ExpW-1:0]  exp_q;

  rkmp_step u_step (
    .state_i     (state_q),
    .char_code_i (char_i.char_code),
    .state_o     (state_n)
  );

  assign char_i.ready = !out_vld_q || value_o.ready;
  assign take         = char_i.valid && char_i.ready;
  assign finish       = take && char_i.last_char;

  always_comb begin
    lexp_ext = ExpCalcW'(letter_exp(state_n.letter, char_i.resistance_like));
    expo     = lexp_ext - $signed({2'b00, state_n.frac_cnt});
    ok = !state_n.err && state_n.digit_seen && (state_n.dot_cnt <= 2'd1) &&
         !(state_n.tail && state_n.dot_cnt != '0) &&
         (state_n.sig_cnt <= SigW'(MaxDigits)) &&
         (state_n.char_cnt <= CntW'(MaxLength)) &&
         (expo >= -8'sd64);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        state_q <= finish ? rkmp_state_t'('0) : state_n;
      end
      if (finish) begin
        out_vld_q <= 1'b1;
      end else if (value_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      vv_q   <= ok;
      mant_q <= ok ? state_n.acc : '0;
      exp_q  <= ok ? expo[ExpW-1:0] : '0;
    end
  end

  assign value_o.valid       = out_vld_q;
  assign value_o.value_valid = vv_q;
  assign value_o.mantissa    = mant_q;
  assign value_o.exponent    = exp_q;

  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_vld_q)
    else $error("no result after last character");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (state_q == rkmp_state_t'('0)))
    else $error("token state not cleared");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !vv_q) |-> (mant_q == '0 && exp_q == '0))
    else $error("rejected token with nonzero fields");

endmodule
